// ===== rtl/particle_pool_update_unit_assert.svh =====
// assertion macros for the particle pool
`ifndef PARTICLE_POOL_UPDATE_UNIT_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PPU_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define PPU_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PPU_ASSERT_IMP(lbl, clk, rstn, a, c)
`define PPU_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ===== rtl/ppu_pkg.sv =====
package ppu_pkg;
    localparam int MAX_PARTICLES = 64;
    localparam int SLOT_W = 6;
    localparam int CNT_W = 7;
    localparam logic [1:0] FUNC_EMIT = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_RSVD = 2'd3;
    localparam logic [1:0] KIND_EMIT = 2'd0;
    localparam logic [1:0] KIND_PART = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic              cap;       // capture input beat
        logic              wr_emit;   // write input particle at slot
        logic              wr_upd;    // write updated particle at slot
        logic              rd;        // read addressed slot
        logic [SLOT_W-1:0] addr;
        logic              mv_start;  // start move computation
        logic              ld_out;    // load output register
        logic [1:0]        out_kind;
        logic              out_last;
    } ppu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [30:0] rd_life;
        logic        mv_done;
    } ppu_sts_t;
endpackage

// ===== rtl/ppu_datapath.sv =====
`include "particle_pool_update_unit_assert.svh"
module ppu_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ppu_pkg::ppu_cmd_t  cmd,
    input  logic [287:0]       in_bits,
    output ppu_pkg::ppu_sts_t  sts,
    output logic [199:0]       out_bits
);
    localparam int N = ppu_pkg::MAX_PARTICLES;

    // memories
    logic [31:0] m_px [N];
    logic [31:0] m_py [N];
    logic [31:0] m_pz [N];
    logic [31:0] m_vx [N];
    logic [31:0] m_vy [N];
    logic [31:0] m_col [N];
    logic [31:0] m_sz [N];
    logic [30:0] m_life [N];

    logic [287:0] in_reg;
    logic [31:0] r_px, r_py, r_pz, r_vx, r_vy, r_col, r_sz;
    logic [30:0] r_life;
    logic [31:0] n_px_reg, n_py_reg;
    logic [30:0] n_life_reg;
    logic signed [63:0] prod_reg;
    logic [1:0] mv_step_reg;
    logic mv_busy_reg;
    logic [199:0] out_reg;
    logic [30:0] dt;

    assign dt = in_reg[287:257];

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            in_reg <= in_bits;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_emit)
        begin
            m_px[cmd.addr] <= in_reg[33:2];
            m_py[cmd.addr] <= in_reg[65:34];
            m_pz[cmd.addr] <= in_reg[97:66];
            m_vx[cmd.addr] <= in_reg[129:98];
            m_vy[cmd.addr] <= in_reg[161:130];
            m_col[cmd.addr] <= in_reg[193:162];
            m_sz[cmd.addr] <= in_reg[225:194];
            m_life[cmd.addr] <= in_reg[256:226];
        end
        else if (cmd.wr_upd)
        begin
            m_px[cmd.addr] <= n_px_reg;
            m_py[cmd.addr] <= n_py_reg;
            m_life[cmd.addr] <= n_life_reg;
        end
        if (cmd.rd)
        begin
            r_px <= m_px[cmd.addr];
            r_py <= m_py[cmd.addr];
            r_pz <= m_pz[cmd.addr];
            r_vx <= m_vx[cmd.addr];
            r_vy <= m_vy[cmd.addr];
            r_col <= m_col[cmd.addr];
            r_sz <= m_sz[cmd.addr];
            r_life <= m_life[cmd.addr];
        end
    end
    assign sts = {r_life, mv_busy_reg && (mv_step_reg == 2'd3)};

    // move unit: one multiply per cycle, x then y
    logic signed [63:0] step_v;
    logic [63:0] sum_v;
    logic [31:0] sat_v;
    logic [31:0] pos_sel;
    always_comb
    begin
        step_v = prod_reg >>> 16;
        pos_sel = (mv_step_reg == 2'd1) ? r_px : r_py;
        sum_v = {{32{pos_sel[31]}}, pos_sel} + step_v;
        if (sum_v[63:31] != {33{sum_v[63]}})
            sat_v = sum_v[63] ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            sat_v = sum_v[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_busy_reg <= 1'b0;
            mv_step_reg <= 2'd0;
        end
        else if (cmd.mv_start)
        begin
            mv_busy_reg <= 1'b1;
            mv_step_reg <= 2'd1;
        end
        else if (mv_busy_reg)
        begin
            mv_step_reg <= mv_step_reg + 2'd1;
            if (mv_step_reg == 2'd3)
            begin
                mv_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mv_start)
        begin
            prod_reg <= $signed(r_vx) * $signed({1'b0, dt});
            n_life_reg <= (r_life > dt) ? r_life - dt : 31'd0;
        end
        else if (mv_busy_reg && mv_step_reg == 2'd1)
        begin
            prod_reg <= $signed(r_vy) * $signed({1'b0, dt});
            n_px_reg <= sat_v;
        end
        else if (mv_busy_reg && mv_step_reg == 2'd3)
        begin
            n_py_reg <= sat_v;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            unique case (cmd.out_kind)
                ppu_pkg::KIND_EMIT: out_reg <= {cmd.out_last, in_reg[256:226],
                    in_reg[225:194], in_reg[193:162], in_reg[97:66], in_reg[65:34],
                    in_reg[33:2], cmd.addr, cmd.out_kind};
                ppu_pkg::KIND_PART: out_reg <= {cmd.out_last, n_life_reg, r_sz, r_col,
                    r_pz, n_py_reg, n_px_reg, cmd.addr, cmd.out_kind};
                default: out_reg <= {1'b1, 191'd0, 6'd0, ppu_pkg::KIND_NONE};
            endcase
        end
    end
    assign out_bits = out_reg;

    `PPU_ASSERT_NXT(a_mv_seq, clk, rst_n, cmd.mv_start, mv_busy_reg)
    `PPU_ASSERT_IMP(a_no_dual_wr, clk, rst_n, cmd.wr_emit, !cmd.wr_upd)
    `PPU_ASSERT_IMP(a_no_start_busy, clk, rst_n, cmd.mv_start, !mv_busy_reg)
endmodule

// ===== rtl/ppu_ctrl.sv =====
`include "particle_pool_update_unit_assert.svh"
module ppu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_func,
    output logic              out_valid,
    input  logic              out_ready,
    output ppu_pkg::ppu_cmd_t cmd,
    input  ppu_pkg::ppu_sts_t sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_FREE_RD, S_FREE_CHK, S_MIN_RD, S_MIN_CHK, S_EMIT_WR,
        S_LAST_RD, S_LAST_CHK, S_NONE_OUT, S_SCAN_RD, S_SCAN_CHK, S_MOVE, S_UPD,
        S_OUT_WAIT
    } state_t;

    localparam logic [ppu_pkg::SLOT_W-1:0] LAST_SLOT = ppu_pkg::SLOT_W'(ppu_pkg::MAX_PARTICLES-1);

    state_t state_reg;
    logic [ppu_pkg::CNT_W-1:0] fill_reg;
    logic [ppu_pkg::SLOT_W-1:0] last_reg, addr_reg, best_reg, slot_reg;
    logic [ppu_pkg::SLOT_W-1:0] lastidx_reg;
    logic [ppu_pkg::CNT_W-1:0] cnt_reg;
    logic [30:0] best_life_reg;
    logic [1:0] func_reg;
    logic mv_pend_reg, ret_scan_reg;
    logic out_valid_reg;

    // next slot, wrapping at the top
    logic [ppu_pkg::SLOT_W-1:0] nxt_addr;
    assign nxt_addr = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 6'd1;

    // top filled slot
    logic [ppu_pkg::CNT_W-1:0] fill_m1;
    assign fill_m1 = fill_reg - 7'd1;

    // least life search: lowest index wins ties
    logic min_take;
    logic [ppu_pkg::SLOT_W-1:0] min_best;
    assign min_take = (addr_reg == '0) || (sts.rd_life < best_life_reg);
    assign min_best = min_take ? addr_reg : best_reg;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.cap = in_valid && in_ready;
        cmd.addr = addr_reg;
        cmd.rd = (state_reg == S_FREE_RD) || (state_reg == S_MIN_RD) ||
                 (state_reg == S_LAST_RD) || (state_reg == S_SCAN_RD);
        cmd.mv_start = (state_reg == S_MOVE) && !mv_pend_reg;
        cmd.wr_emit = (state_reg == S_EMIT_WR);
        cmd.wr_upd = (state_reg == S_UPD);
        cmd.ld_out = (state_reg == S_EMIT_WR) || (state_reg == S_UPD) ||
                     (state_reg == S_NONE_OUT);
        if (state_reg == S_EMIT_WR)
        begin
            cmd.addr = slot_reg;
            cmd.out_kind = ppu_pkg::KIND_EMIT;
            cmd.out_last = 1'b1;
        end
        if (state_reg == S_UPD)
        begin
            cmd.out_kind = ppu_pkg::KIND_PART;
            cmd.out_last = (addr_reg == lastidx_reg);
        end
        if (state_reg == S_NONE_OUT)
        begin
            cmd.out_kind = ppu_pkg::KIND_NONE;
            cmd.out_last = 1'b1;
        end
    end

    // controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            last_reg <= '0;
            addr_reg <= '0;
            best_reg <= '0;
            slot_reg <= '0;
            lastidx_reg <= '0;
            cnt_reg <= '0;
            best_life_reg <= '0;
            func_reg <= '0;
            mv_pend_reg <= 1'b0;
            ret_scan_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        func_reg <= in_func;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    unique case (func_reg)
                        ppu_pkg::FUNC_EMIT:
                        begin
                            if (fill_reg < 7'(ppu_pkg::MAX_PARTICLES))
                            begin
                                slot_reg <= fill_reg[ppu_pkg::SLOT_W-1:0];
                                fill_reg <= fill_reg + 7'd1;
                                state_reg <= S_EMIT_WR;
                            end
                            else
                            begin
                                addr_reg <= (last_reg == LAST_SLOT) ? '0 : last_reg + 6'd1;
                                cnt_reg <= '0;
                                state_reg <= S_FREE_RD;
                            end
                        end
                        ppu_pkg::FUNC_TICK:
                        begin
                            if (fill_reg == '0)
                            begin
                                state_reg <= S_NONE_OUT;
                            end
                            else
                            begin
                                addr_reg <= fill_m1[ppu_pkg::SLOT_W-1:0];
                                state_reg <= S_LAST_RD;
                            end
                        end
                        ppu_pkg::FUNC_CLEAR:
                        begin
                            fill_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                // circular search for a dead slot
                S_FREE_RD: state_reg <= S_FREE_CHK;
                S_FREE_CHK:
                begin
                    if (sts.rd_life == '0)
                    begin
                        slot_reg <= addr_reg;
                        last_reg <= addr_reg;
                        state_reg <= S_EMIT_WR;
                    end
                    else if (cnt_reg == 7'(ppu_pkg::MAX_PARTICLES-1))
                    begin
                        addr_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_MIN_RD;
                    end
                    else
                    begin
                        addr_reg <= nxt_addr;
                        cnt_reg <= cnt_reg + 7'd1;
                        state_reg <= S_FREE_RD;
                    end
                end
                // lowest index with least life
                S_MIN_RD: state_reg <= S_MIN_CHK;
                S_MIN_CHK:
                begin
                    if (min_take)
                    begin
                        best_life_reg <= sts.rd_life;
                    end
                    best_reg <= min_best;
                    if (addr_reg == LAST_SLOT)
                    begin
                        slot_reg <= min_best;
                        last_reg <= min_best;
                        state_reg <= S_EMIT_WR;
                    end
                    else
                    begin
                        addr_reg <= nxt_addr;
                        state_reg <= S_MIN_RD;
                    end
                end
                S_EMIT_WR:
                begin
                    out_valid_reg <= 1'b1;
                    ret_scan_reg <= 1'b0;
                    state_reg <= S_OUT_WAIT;
                end
                // tick: find the highest live filled slot first
                S_LAST_RD: state_reg <= S_LAST_CHK;
                S_LAST_CHK:
                begin
                    if (sts.rd_life != '0)
                    begin
                        lastidx_reg <= addr_reg;
                        addr_reg <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                    else if (addr_reg == '0)
                    begin
                        state_reg <= S_NONE_OUT;
                    end
                    else
                    begin
                        addr_reg <= addr_reg - 6'd1;
                        state_reg <= S_LAST_RD;
                    end
                end
                // tick with nothing alive
                S_NONE_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    ret_scan_reg <= 1'b0;
                    state_reg <= S_OUT_WAIT;
                end
                // tick: walk slots up to the last live one
                S_SCAN_RD: state_reg <= S_SCAN_CHK;
                S_SCAN_CHK:
                begin
                    if (sts.rd_life != '0)
                    begin
                        mv_pend_reg <= 1'b0;
                        state_reg <= S_MOVE;
                    end
                    else
                    begin
                        addr_reg <= nxt_addr;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_MOVE:
                begin
                    mv_pend_reg <= 1'b1;
                    if (sts.mv_done)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    out_valid_reg <= 1'b1;
                    ret_scan_reg <= 1'b1;
                    state_reg <= S_OUT_WAIT;
                end
                S_OUT_WAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (ret_scan_reg && addr_reg != lastidx_reg)
                        begin
                            addr_reg <= nxt_addr;
                            state_reg <= S_SCAN_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `PPU_ASSERT_IMP(a_rdy_idle, clk, rst_n, in_ready, state_reg == S_IDLE)
    `PPU_ASSERT_IMP(a_fill_max, clk, rst_n, 1'b1, fill_reg <= 7'(ppu_pkg::MAX_PARTICLES))
    `PPU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

// ===== rtl/particle_pool_update_unit.sv =====
// channel  dir  tdata fields, low bit first                      tlast
// s_axis   in   func, pos_x, pos_y, pos_z, vel_x, vel_y,         -
//               color_in, size_in, life_in, delta_time (288 bits)
// m_axis   out  kind, slot, out_pos_x, out_pos_y, out_pos_z,     is_last
//               out_color, out_size, out_life (199 bits, 200 with pad)
// emit while filling: write the next unfilled slot, send its beat, then accept again
// a full pool searches all slots, from after the last reused one, for a dead slot,
// then, if none is dead, every slot for least life
// tick walks down from the top filled slot to the last live one,
// then up from slot 0 to it, moving and sending each live slot in turn
// reset clears the fill count and the last reused slot; stores are unset
// a stalled output beat holds the controller and keeps the input not ready
module particle_pool_update_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,  // func, pos_x, pos_y, pos_z, vel_x, vel_y,
                                        // color_in, size_in, life_in, delta_time
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata,  // kind, slot, out_pos_x, out_pos_y,
                                        // out_pos_z, out_color, out_size, out_life
    output logic         m_axis_tlast
);
    ppu_pkg::ppu_cmd_t cmd;
    ppu_pkg::ppu_sts_t sts;
    logic [199:0] ob;

    ppu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_func(s_axis_tdata[1:0]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .sts(sts)
    );

    ppu_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_bits(s_axis_tdata),
        .sts(sts), .out_bits(ob)
    );

    assign m_axis_tdata = {1'b0, ob[198:0]};
    assign m_axis_tlast = ob[199];
endmodule

// ===== test/tb_particle_pool_update_unit.sv =====
`timescale 1ns / 1ps

// one expected output beat of the pool
typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] color;
    logic [31:0] size;
    logic [30:0] life;
    logic        last;
} pool_beat_t;

class pool_scoreboard;
    logic [31:0] pos_x [64];
    logic [31:0] pos_y [64];
    logic [31:0] pos_z [64];
    logic [31:0] vel_x [64];
    logic [31:0] vel_y [64];
    logic [31:0] color [64];
    logic [31:0] size [64];
    logic [30:0] life [64];
    int unsigned fill_count;
    logic [5:0]  last_reused;
    pool_beat_t  pending [$];
    int          mismatches;

    function new();
        fill_count = 0;
        last_reused = 0;
        mismatches = 0;
    endfunction

    function pool_beat_t slot_beat(logic [1:0] k, int s, logic l);
        pool_beat_t b;
        b.kind = k;
        b.slot = s[5:0];
        b.px = pos_x[s];
        b.py = pos_y[s];
        b.pz = pos_z[s];
        b.color = color[s];
        b.size = size[s];
        b.life = life[s];
        b.last = l;
        return b;
    endfunction

    // position step with floor rounding and signed saturation
    function logic [31:0] move_axis(logic [31:0] p, logic [31:0] v, logic [30:0] dt);
        longint prod;
        longint step;
        longint sum;
        prod = longint'($signed(v)) * longint'({1'b0, dt});
        step = prod >>> 16;
        sum = longint'($signed(p)) + step;
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    function int pick_slot();
        int idx;
        int best;
        if (fill_count < 64)
        begin
            fill_count++;
            return fill_count - 1;
        end
        for (int k = 0; k < 64; k++)
        begin
            idx = (last_reused + 1 + k) % 64;
            if (life[idx] == 0)
            begin
                last_reused = idx[5:0];
                return idx;
            end
        end
        best = 0;
        for (int k = 1; k < 64; k++)
            if (life[k] < life[best])
                best = k;
        last_reused = best[5:0];
        return best;
    endfunction

    // note an accepted input beat
    function void note_input(logic [287:0] d);
        int s;
        int lastidx;
        int n;
        logic [30:0] dt;
        bit alive [64];
        pool_beat_t b;
        dt = d[287:257];
        if (d[1:0] == ppu_pkg::FUNC_EMIT)
        begin
            s = pick_slot();
            pos_x[s] = d[33:2];
            pos_y[s] = d[65:34];
            pos_z[s] = d[97:66];
            vel_x[s] = d[129:98];
            vel_y[s] = d[161:130];
            color[s] = d[193:162];
            size[s] = d[225:194];
            life[s] = d[256:226];
            pending.push_back(slot_beat(ppu_pkg::KIND_EMIT, s, 1'b1));
        end
        else if (d[1:0] == ppu_pkg::FUNC_CLEAR)
            fill_count = 0;
        else if (d[1:0] == ppu_pkg::FUNC_TICK)
        begin
            n = 0;
            lastidx = 0;
            for (int i = 0; i < 64; i++)
            begin
                alive[i] = (i < fill_count) && (life[i] != 0);
                if (alive[i])
                begin
                    n++;
                    lastidx = i;
                end
            end
            if (n == 0)
            begin
                b = '{ppu_pkg::KIND_NONE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'd0,
                      1'b1};
                pending.push_back(b);
            end
            for (int i = 0; i < 64; i++)
            begin
                if (!alive[i])
                    continue;
                life[i] = (life[i] > dt) ? life[i] - dt : 31'd0;
                pos_x[i] = move_axis(pos_x[i], vel_x[i], dt);
                pos_y[i] = move_axis(pos_y[i], vel_y[i], dt);
                pending.push_back(slot_beat(ppu_pkg::KIND_PART, i, i == lastidx));
            end
        end
    endfunction

    // compare an output beat with the oldest expectation
    function void check_output(logic [199:0] d, logic tl);
        pool_beat_t e;
        pool_beat_t a;
        a = '{d[1:0], d[7:2], d[39:8], d[71:40], d[103:72], d[135:104], d[167:136],
              d[198:168], tl};
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output beat kind %0d slot %0d", a.kind, a.slot);
            return;
        end
        e = pending.pop_front();
        if (a !== e)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch exp: k%0d s%0d x%h y%h z%h c%h sz%h l%h t%0d",
                         e.kind, e.slot, e.px, e.py, e.pz, e.color, e.size, e.life,
                         e.last);
                $display("         act: k%0d s%0d x%h y%h z%h c%h sz%h l%h t%0d",
                         a.kind, a.slot, a.px, a.py, a.pz, a.color, a.size, a.life,
                         a.last);
            end
        end
    endfunction
endclass

module tb_particle_pool_update_unit;
    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;
    logic         m_axis_tlast;

    pool_scoreboard pool;
    bit             no_idle;

    particle_pool_update_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // output side: random stall, check every accepted beat
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            pool.check_output(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= no_idle || ($urandom_range(99) >= 19);
    end

    function automatic logic [30:0] rnd31();
        return 31'($urandom);
    endfunction

    // send one input beat, with random idle before it
    task automatic send_beat(logic [1:0] f, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                             logic [31:0] c, logic [31:0] sz, logic [30:0] lf,
                             logic [30:0] dt);
        while (!no_idle && $urandom_range(99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata <= {dt, lf, sz, c, vy, vx, pz, py, px, f};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pool.note_input({dt, lf, sz, c, vy, vx, pz, py, px, f});
    endtask

    task automatic emit(logic [30:0] lf, logic [31:0] vx, logic [31:0] vy);
        send_beat(ppu_pkg::FUNC_EMIT, $urandom, $urandom, $urandom, vx, vy, $urandom,
                  $urandom, lf, rnd31());
    endtask

    task automatic tick(logic [30:0] dt);
        send_beat(ppu_pkg::FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, rnd31(), dt);
    endtask

    function automatic logic [30:0] rand_life();
        case ($urandom_range(5))
            0: return 31'd0;
            1: return 31'h7fffffff;
            2: return 31'($urandom_range(3));
            default: return 31'($urandom_range(32'h00200000));
        endcase
    endfunction

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pool.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        pool = new();
        no_idle = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tick on empty pool, extremes, saturation, unused code
        tick(31'h7fffffff);
        send_beat(ppu_pkg::FUNC_EMIT, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                  32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff,
                  31'h7fffffff, 31'h7fffffff);
        send_beat(ppu_pkg::FUNC_EMIT, 32'h80000000, 32'h7fffffff, 32'h0, 32'h80000000,
                  32'h7fffffff, 32'h0, 32'h0, 31'd1, 31'd0);
        send_beat(ppu_pkg::FUNC_EMIT, 32'h0, 32'h0, 32'h0, 32'hffffffff, 32'h00000001,
                  32'h0, 32'h0, 31'd0, 31'd0);
        tick(31'd0);
        tick(31'd1);
        tick(31'h7fffffff);
        tick(31'h7fffffff);
        send_beat(ppu_pkg::FUNC_RSVD, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, 31'h7fffffff, 31'h7fffffff);
        send_beat(ppu_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, rnd31(), rnd31());
        tick(31'd5);

        // fill the pool to force reuse search and least-life pick
        for (int i = 0; i < 66; i++)
            emit(31'($urandom_range(1000, 1)), rand_vel(), rand_vel());
        emit(31'd7, rand_vel(), rand_vel());
        tick(31'd600);
        emit(31'd9, rand_vel(), rand_vel());

        // hold off until the pool has answered everything
        wait_drained();

        // random sequences: emits and ticks, occasional clear and unused code
        sent = 0;
        while (sent < 400)
        begin
            no_idle = (sent >= 150 && sent < 200);
            case ($urandom_range(19)) inside
                0: send_beat(ppu_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, rnd31(), rnd31());
                1: send_beat(ppu_pkg::FUNC_RSVD, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, rnd31(), rnd31());
                [2:5]: tick($urandom_range(3) == 0 ? rnd31()
                                                   : 31'($urandom_range(32'h40000)));
                default: emit(rand_life(), rand_vel(), rand_vel());
            endcase
            sent++;
        end
        no_idle = 1'b0;

        wait_drained();
        if (pool.mismatches == 0 && pool.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ppu_pkg.sv
rtl/ppu_datapath.sv
rtl/ppu_ctrl.sv
rtl/particle_pool_update_unit.sv
test/tb_particle_pool_update_unit.sv
